// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FUPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FUPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/fupa_pkg.sv
`default_nettype none

package fupa_pkg;

  localparam int NUM_UNITS   = 16;
  localparam int NUM_CLASSES = 8;

  localparam int CMD_W     = 2;
  localparam int CLASS_W   = 3;
  localparam int UNIT_W    = 4;
  localparam int STATUS_W  = 3;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 4;
  localparam int RANK_W    = $clog2(NUM_UNITS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_ALL_BUSY = 3'd1,
    ST_NO_CAP   = 3'd2,
    ST_REL_OK   = 3'd3,
    ST_REL_REJ  = 3'd4,
    ST_TICK     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LAUNCH,
    S_SCAN,
    S_FINISH
  } state_e;

  // Search token walking the cell chain.
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic              hi_found;
    logic [UNIT_W-1:0] hi_unit;
    logic [RANK_W-1:0] hi_rank;
    logic              lo_found;
    logic [UNIT_W-1:0] lo_unit;
    logic [RANK_W-1:0] lo_rank;
  } scan_tok_t;

  typedef struct packed {
    logic set_busy;
    logic mark;
    logic tick;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/fupa_ifs.sv
`default_nettype none

interface fupa_in_if;
  import fupa_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CLASS_W-1:0]  op_class;
  logic [UNIT_W-1:0]   unit_index;

  modport source (output valid, command, op_class, unit_index, input ready);
  modport sink   (input valid, command, op_class, unit_index, output ready);
endinterface

interface fupa_out_if;
  import fupa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [UNIT_W-1:0]   granted_unit;
  logic                all_idle;

  modport source (output valid, status, granted_unit, all_idle, input ready);
  modport sink   (input valid, status, granted_unit, all_idle, output ready);
endinterface

`default_nettype wire

// File: hdl/fupa_cell.sv
`default_nettype none

module fupa_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [fupa_pkg::UNIT_W-1:0] unit_id_i,
  input  wire logic                       member_i,
  input  wire logic [fupa_pkg::RANK_W-1:0] start_i,
  input  wire fupa_pkg::cell_ctrl_t       ctrl_i,
  input  wire fupa_pkg::scan_tok_t        tok_i,
  output fupa_pkg::scan_tok_t             tok_o,
  output logic                            busy_o,
  output logic                            pending_o
);
  import fupa_pkg::*;

  scan_tok_t tok_d, tok_q;
  logic      busy_d, busy_q;
  logic      pend_d, pend_q;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && member_i) begin
      tok_d.rank = tok_i.rank + RANK_W'(1);
      if (!busy_q) begin
        if (tok_i.rank >= start_i) begin
          if (!tok_i.hi_found) begin
            tok_d.hi_found = 1'b1;
            tok_d.hi_unit  = unit_id_i;
            tok_d.hi_rank  = tok_i.rank;
          end
        end else if (!tok_i.lo_found) begin
          tok_d.lo_found = 1'b1;
          tok_d.lo_unit  = unit_id_i;
          tok_d.lo_rank  = tok_i.rank;
        end
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    pend_d = pend_q;
    if (ctrl_i.tick) begin
      if (pend_q) begin
        busy_d = 1'b0;
      end
      pend_d = 1'b0;
    end
    if (ctrl_i.mark && busy_q) begin
      pend_d = 1'b1;
    end
    if (ctrl_i.set_busy) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      busy_q <= busy_d;
      pend_q <= pend_d;
    end
  end

  assign tok_o     = tok_q;
  assign busy_o    = busy_q;
  assign pending_o = pend_q;

endmodule

`default_nettype wire

// File: hdl/function_unit_pool_allocator_core.sv
// Round-robin allocator for a pool of NUM_UNITS execution units. Eight class
// registers (cfg index 0..7) hold the mask of units each operation class may
// use; write them only while the block is idle. One beat is handled at a
// time. Release, tick and the unused command go from S_IDLE to S_FINISH,
// which loads their result beat; a request for a class with no capable unit
// passes S_PREP first. A searching request passes S_PREP, S_LAUNCH and
// S_SCAN, in which a search token walks a chain of one cell per unit, one
// cell per cycle, each cell holding its unit's busy and release-pending
// bits. The output register lets the next beat be accepted while a result
// still waits to be taken.
`default_nettype none

`include "assert_macros.svh"

module function_unit_pool_allocator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fupa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fupa_pkg::MASK_W-1:0]    cfg_data_i,
  fupa_in_if.sink                            in_bus,
  fupa_out_if.source                         out_bus
);
  import fupa_pkg::*;

  state_e state_q, state_d;

  logic [MASK_W-1:0]  mask_q [NUM_CLASSES];
  logic [POS_W-1:0]   pos_q  [NUM_CLASSES];

  logic [CLASS_W-1:0] class_q;
  logic [UNIT_W-1:0]  unit_q;
  logic [RANK_W-1:0]  n_q, n_d;
  logic [RANK_W-1:0]  start_q, start_d;
  status_e            res_status_q, res_status_d;
  logic [UNIT_W-1:0]  res_unit_q, res_unit_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [UNIT_W-1:0]   out_unit_q;
  logic                out_idle_q;

  logic               accept;
  logic               res_we;
  logic               prep_we;
  logic               pos_we;
  logic [POS_W-1:0]   pos_wdata;
  logic               out_load;
  logic               grant_en;
  logic               rel_en;
  logic               tick_en;
  logic [RANK_W-1:0]  pick_rank;
  logic [RANK_W-1:0]  pick_next;
  logic [MASK_W-1:0]  cur_mask;

  scan_tok_t             tok [NUM_UNITS+1];
  logic [NUM_UNITS:0]    tok_vld;
  logic [NUM_UNITS-1:0]  busy_vec;
  logic [NUM_UNITS-1:0]  pend_vec;

  assign cur_mask = mask_q[class_q];
  assign accept   = in_bus.valid && in_bus.ready;
  assign rel_en   = accept && (cmd_e'(in_bus.command) == CMD_RELEASE);
  assign tick_en  = accept && (cmd_e'(in_bus.command) == CMD_TICK);
  assign grant_en = out_load && (res_status_q == ST_GRANTED);

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = (state_q == S_LAUNCH);
  end

  for (genvar g = 0; g < NUM_UNITS; g++) begin : g_cell
    cell_ctrl_t ctrl;

    always_comb begin
      ctrl.set_busy = grant_en && (res_unit_q == UNIT_W'(g));
      ctrl.mark     = rel_en && (in_bus.unit_index == UNIT_W'(g));
      ctrl.tick     = tick_en;
    end

    fupa_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .unit_id_i (UNIT_W'(g)),
      .member_i  (cur_mask[g]),
      .start_i   (start_q),
      .ctrl_i    (ctrl),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1]),
      .busy_o    (busy_vec[g]),
      .pending_o (pend_vec[g])
    );
  end

  for (genvar g = 0; g <= NUM_UNITS; g++) begin : g_vld
    assign tok_vld[g] = tok[g].valid;
  end

  always_comb begin
    state_d      = state_q;
    in_bus.ready = 1'b0;
    res_we       = 1'b0;
    res_status_d = res_status_q;
    res_unit_d   = '0;
    prep_we      = 1'b0;
    n_d          = RANK_W'($countones(cur_mask[NUM_UNITS-1:0]));
    start_d      = '0;
    pos_we       = 1'b0;
    pick_rank    = start_q;
    pick_next    = '0;
    pos_wdata    = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          res_we = 1'b1;
          unique case (cmd_e'(in_bus.command))
            CMD_REQUEST: begin
              state_d = S_PREP;
            end
            CMD_RELEASE: begin
              res_status_d = ((32'(in_bus.unit_index) < NUM_UNITS) &&
                              busy_vec[in_bus.unit_index]) ? ST_REL_OK : ST_REL_REJ;
              state_d = S_FINISH;
            end
            CMD_TICK: begin
              res_status_d = ST_TICK;
              state_d      = S_FINISH;
            end
            CMD_UNUSED: begin
              res_status_d = ST_REL_REJ;
              state_d      = S_FINISH;
            end
            default: begin
              res_status_d = ST_REL_REJ;
              state_d      = S_FINISH;
            end
          endcase
        end
      end

      S_PREP: begin
        if ((32'(class_q) >= NUM_CLASSES) || (n_d == '0)) begin
          res_we       = 1'b1;
          res_status_d = ST_NO_CAP;
          state_d      = S_FINISH;
        end else begin
          prep_we = 1'b1;
          start_d = (RANK_W'(pos_q[class_q]) >= n_d) ? '0 : RANK_W'(pos_q[class_q]);
          state_d = S_LAUNCH;
        end
      end

      S_LAUNCH: begin
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (tok[NUM_UNITS].valid) begin
          res_we = 1'b1;
          priority if (tok[NUM_UNITS].hi_found) begin
            res_status_d = ST_GRANTED;
            res_unit_d   = tok[NUM_UNITS].hi_unit;
            pick_rank    = tok[NUM_UNITS].hi_rank;
          end else if (tok[NUM_UNITS].lo_found) begin
            res_status_d = ST_GRANTED;
            res_unit_d   = tok[NUM_UNITS].lo_unit;
            pick_rank    = tok[NUM_UNITS].lo_rank;
          end else begin
            res_status_d = ST_ALL_BUSY;
            pick_rank    = start_q;
          end
          pick_next = pick_rank + RANK_W'(1);
          pos_we    = 1'b1;
          pos_wdata = (pick_next == n_q) ? '0 : POS_W'(pick_next);
          state_d   = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_bus.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        mask_q[c] <= '0;
        pos_q[c]  <= '0;
      end
    end else begin
      if (cfg_we_i && (32'(cfg_idx_i) < NUM_CLASSES)) begin
        mask_q[cfg_idx_i] <= cfg_data_i;
      end
      if (pos_we) begin
        pos_q[class_q] <= pos_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      class_q <= in_bus.op_class;
      unit_q  <= in_bus.unit_index;
    end
    if (prep_we) begin
      n_q     <= n_d;
      start_q <= start_d;
    end
    if (res_we) begin
      res_status_q <= res_status_d;
      res_unit_q   <= res_unit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_unit_q   <= res_unit_q;
      out_idle_q   <= (res_status_q == ST_GRANTED) ? 1'b0 : ~|busy_vec;
    end
  end

  assign out_bus.valid        = out_valid_q;
  assign out_bus.status       = out_status_q;
  assign out_bus.granted_unit = out_unit_q;
  assign out_bus.all_idle     = out_idle_q;

  `FUPA_ASSERT_ALWAYS(a_tok_single, $onehot0(tok_vld), "more than one search token in chain")
  `FUPA_ASSERT(a_pend_busy, (pend_vec & ~busy_vec) == '0, "release pending on a free unit")
  `FUPA_ASSERT(a_tail_in_scan, tok_vld[NUM_UNITS] |-> state_q == S_SCAN, "token left chain late")
  `FUPA_ASSERT(a_grant_free, grant_en |-> !busy_vec[res_unit_q], "grant of a busy unit")
  `FUPA_ASSERT(a_rel_unit, rel_en |=> unit_q == $past(in_bus.unit_index), "release unit lost")

endmodule

`default_nettype wire
